/* hw/rtl/qrt_pkg.sv */
package qrt_pkg;

  localparam int COORD_W  = 32;
  localparam int QUAT_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Rotation coefficients are quadratic in the quaternion, scale 2^28.
  localparam int PROD_Q_W = 2 * QUAT_W;
  localparam int COEF_W   = PROD_Q_W + 2;

  // A point coordinate is split into a signed high half and an unsigned low half.
  localparam int HALF_W   = COORD_W / 2;
  localparam int PH_W     = COEF_W + HALF_W;
  localparam int PL_W     = COEF_W + HALF_W + 1;
  localparam int SH_W     = PH_W + 2;
  localparam int SL_W     = PL_W + 2;
  localparam int T_W      = SH_W + 1;
  localparam int FRAC_SHIFT = 12;
  localparam int R_W      = T_W - FRAC_SHIFT + 1;

  // Half of one output LSB at the full product scale of 2^28.
  localparam int ROUND_BIT = HALF_W + FRAC_SHIFT - 1;

  localparam int PIPE_DEPTH = 4;

  // Cycles from a register write until the coefficients reflect it.
  localparam int SETTLE_CYCLES = 2;
  localparam int SETTLE_W      = 2;

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  typedef struct packed {
    coef_t c0;
    coef_t c1;
    coef_t c2;
  } coef_row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X   = 3'd0,
    REG_QUAT_Y   = 3'd1,
    REG_QUAT_Z   = 3'd2,
    REG_QUAT_W   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } cfg_reg_t;

endpackage

/* hw/rtl/qrt_coef.sv */
module qrt_coef (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [qrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qrt_pkg::COORD_W-1:0]    cfg_data,
  output qrt_pkg::coef_row_t             row_x,
  output qrt_pkg::coef_row_t             row_y,
  output qrt_pkg::coef_row_t             row_z,
  output qrt_pkg::coord_t                off_x,
  output qrt_pkg::coord_t                off_y,
  output qrt_pkg::coord_t                off_z,
  output logic                           settling
);
  import qrt_pkg::*;

  quat_t qx, qy, qz, qw;
  logic [SETTLE_W-1:0] settle_cnt;

  logic signed [PROD_Q_W-1:0] pww, pxx, pyy, pzz, pxy, pwz, pxz, pwy, pyz, pwx;

  always_ff @(posedge clk) begin
    if (rst) begin
      qx <= '0;
      qy <= '0;
      qz <= '0;
      qw <= QUAT_ONE;
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUAT_X:   qx <= quat_t'(cfg_data[QUAT_W-1:0]);
        REG_QUAT_Y:   qy <= quat_t'(cfg_data[QUAT_W-1:0]);
        REG_QUAT_Z:   qz <= quat_t'(cfg_data[QUAT_W-1:0]);
        REG_QUAT_W:   qw <= quat_t'(cfg_data[QUAT_W-1:0]);
        REG_OFFSET_X: off_x <= coord_t'(cfg_data);
        REG_OFFSET_Y: off_y <= coord_t'(cfg_data);
        REG_OFFSET_Z: off_z <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // The coefficient pipeline lags the registers; hold off items until it catches up.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_valid) begin
      settle_cnt <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 1'b1;
    end
  end

  assign settling = (settle_cnt != '0);

  always_ff @(posedge clk) begin
    pww <= qw * qw;
    pxx <= qx * qx;
    pyy <= qy * qy;
    pzz <= qz * qz;
    pxy <= qx * qy;
    pwz <= qw * qz;
    pxz <= qx * qz;
    pwy <= qw * qy;
    pyz <= qy * qz;
    pwx <= qw * qx;
  end

  always_ff @(posedge clk) begin
    row_x.c0 <= coef_t'(pww) + coef_t'(pxx) - coef_t'(pyy) - coef_t'(pzz);
    row_x.c1 <= (coef_t'(pxy) - coef_t'(pwz)) <<< 1;
    row_x.c2 <= (coef_t'(pxz) + coef_t'(pwy)) <<< 1;
    row_y.c0 <= (coef_t'(pxy) + coef_t'(pwz)) <<< 1;
    row_y.c1 <= coef_t'(pww) - coef_t'(pxx) + coef_t'(pyy) - coef_t'(pzz);
    row_y.c2 <= (coef_t'(pyz) - coef_t'(pwx)) <<< 1;
    row_z.c0 <= (coef_t'(pxz) - coef_t'(pwy)) <<< 1;
    row_z.c1 <= (coef_t'(pyz) + coef_t'(pwx)) <<< 1;
    row_z.c2 <= coef_t'(pww) - coef_t'(pxx) - coef_t'(pyy) + coef_t'(pzz);
  end

endmodule

/* hw/rtl/qrt_row.sv */
module qrt_row (
  input  logic               clk,
  input  qrt_pkg::coef_row_t row,
  input  qrt_pkg::coord_t    offset,
  input  qrt_pkg::coord_t    point_x,
  input  qrt_pkg::coord_t    point_y,
  input  qrt_pkg::coord_t    point_z,
  output qrt_pkg::coord_t    moved,
  output logic               clip
);
  import qrt_pkg::*;

  localparam logic signed [SL_W-1:0] ROUND_HALF = SL_W'(1) <<< ROUND_BIT;

  coord_t pt [3];
  coef_t  c  [3];

  logic signed [PH_W-1:0] ph_next [3];
  logic signed [PL_W-1:0] pl_next [3];
  logic signed [PH_W-1:0] ph [3];
  logic signed [PL_W-1:0] pl [3];
  logic signed [SH_W-1:0] sh;
  logic signed [SL_W-1:0] sl;
  logic signed [T_W-1:0]  tsum;
  logic signed [R_W-1:0]  r_next;
  coord_t                 moved_next;
  logic                   clip_next;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;
  assign c[0]  = row.c0;
  assign c[1]  = row.c1;
  assign c[2]  = row.c2;

  // Stage 1: exact partial products against each half of the coordinate.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ph_next[j] = c[j] * $signed(pt[j][COORD_W-1:HALF_W]);
      pl_next[j] = c[j] * $signed({1'b0, pt[j][HALF_W-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      ph[j] <= ph_next[j];
      pl[j] <= pl_next[j];
    end
  end

  // Stage 2: sum each half separately; the rounding half rides on the low sum.
  always_ff @(posedge clk) begin
    sh <= SH_W'(ph[0]) + SH_W'(ph[1]) + SH_W'(ph[2]);
    sl <= SL_W'(pl[0]) + SL_W'(pl[1]) + SL_W'(pl[2]) + ROUND_HALF;
  end

  // Stage 3: recombine the halves at scale 2^12 above the output LSB.
  always_ff @(posedge clk) begin
    tsum <= T_W'(sh) + T_W'(sl >>> HALF_W);
  end

  // Stage 4: drop the remaining fraction, add the offset, then clamp.
  always_comb begin
    r_next = R_W'(tsum >>> FRAC_SHIFT) + R_W'(offset);
    clip_next = (r_next[R_W-1:COORD_W-1] != '0) && (r_next[R_W-1:COORD_W-1] != '1);
    if (clip_next) begin
      moved_next = r_next[R_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      moved_next = r_next[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    moved <= moved_next;
    clip  <= clip_next;
  end

endmodule

/* hw/rtl/quaternion_rigid_transform.sv */
// Rotates a Q16.16 point by a Q2.14 orientation quaternion and adds an offset.
//
// Input: pulse start with point_x/y/z while busy is low; the point is taken at
// that edge. A new point may be taken every cycle. Busy is high after reset
// and after each register write while the rotation coefficients are rebuilt
// from the quaternion; otherwise it stays low.
// Configuration: cfg_valid with cfg_index and cfg_data; cfg_ready is always
// high, so every write is a single-cycle transfer. Write only while no point
// is in flight. Index 0..3 loads the quaternion, 4..6 the offset.
// Output: done is high for exactly one cycle with moved_x/y/z and clipped. It
// comes after the multiply, two add stages, and round and clamp registers,
// one result per point, in order. Throughput is one point per cycle while busy
// is low; the receiver cannot stall, so results are never held.
// Reset clears the pipeline valid bits, loads the identity quaternion and a
// zero offset, and drops any point in flight.
module quaternion_rigid_transform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [qrt_pkg::COORD_W-1:0]   point_x,
  input  logic [qrt_pkg::COORD_W-1:0]   point_y,
  input  logic [qrt_pkg::COORD_W-1:0]   point_z,
  output logic                          done,
  output logic [qrt_pkg::COORD_W-1:0]   moved_x,
  output logic [qrt_pkg::COORD_W-1:0]   moved_y,
  output logic [qrt_pkg::COORD_W-1:0]   moved_z,
  output logic                          clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qrt_pkg::COORD_W-1:0]   cfg_data
);
  import qrt_pkg::*;

  coef_row_t row_x, row_y, row_z;
  coord_t    off_x, off_y, off_z;
  coord_t    res_x, res_y, res_z;
  logic      clip_x, clip_y, clip_z;
  logic      settling;
  logic      accept;
  logic [PIPE_DEPTH-1:0] stage_vld;

  assign cfg_ready = 1'b1;
  assign busy      = settling;
  assign accept    = start && !busy;

  qrt_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_x     (row_x),
    .row_y     (row_y),
    .row_z     (row_z),
    .off_x     (off_x),
    .off_y     (off_y),
    .off_z     (off_z),
    .settling  (settling)
  );

  qrt_row u_row_x (
    .clk     (clk),
    .row     (row_x),
    .offset  (off_x),
    .point_x (coord_t'(point_x)),
    .point_y (coord_t'(point_y)),
    .point_z (coord_t'(point_z)),
    .moved   (res_x),
    .clip    (clip_x)
  );

  qrt_row u_row_y (
    .clk     (clk),
    .row     (row_y),
    .offset  (off_y),
    .point_x (coord_t'(point_x)),
    .point_y (coord_t'(point_y)),
    .point_z (coord_t'(point_z)),
    .moved   (res_y),
    .clip    (clip_y)
  );

  qrt_row u_row_z (
    .clk     (clk),
    .row     (row_z),
    .offset  (off_z),
    .point_x (coord_t'(point_x)),
    .point_y (coord_t'(point_y)),
    .point_z (coord_t'(point_z)),
    .moved   (res_z),
    .clip    (clip_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      stage_vld <= {stage_vld[PIPE_DEPTH-2:0], accept};
    end
  end

  assign done    = stage_vld[PIPE_DEPTH-1];
  assign moved_x = res_x;
  assign moved_y = res_y;
  assign moved_z = res_z;
  assign clipped = clip_x || clip_y || clip_z;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted point produced no result after four cycles");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result strobe without a matching accepted point");

  a_write_blocks_start: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("points accepted while coefficients are being rebuilt");

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import qrt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int NUM_REGS = 7;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 2;
  localparam int RANDOM_PHASES = 10;
  localparam int POINTS_PER_PHASE = 75;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clip;
  } moved_pt_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [COORD_W-1:0]   point_x;
  logic [COORD_W-1:0]   point_y;
  logic [COORD_W-1:0]   point_z;
  logic                 done;
  logic [COORD_W-1:0]   moved_x;
  logic [COORD_W-1:0]   moved_y;
  logic [COORD_W-1:0]   moved_z;
  logic                 clipped;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  // Percentage of points followed by an idle gap on the input side.
  int gap_rate;

  // Approximately unit quaternions (x, y, z, w) for rigid rotations.
  int unit_q[8][4] = '{
    '{0, 0, 0, 16384},
    '{11585, 0, 0, 11585},
    '{0, 11585, 0, 11585},
    '{0, 0, 11585, 11585},
    '{8192, 8192, 8192, 8192},
    '{-8192, 8192, -8192, 8192},
    '{0, 0, 16384, 0},
    '{6270, 0, 0, 15137}
  };
  int quat_edges[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
  coord_t coord_edges[8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                             32'h0000_0001, 32'h0000_8000, 32'h7fff_8000, 32'hffff_8000};

  class transform_scoreboard;
    quat_t     quat[4];
    coord_t    offset[3];
    moved_pt_t pending_moves[$];
    int        errors;

    function new();
      quat = '{QUAT_W'(0), QUAT_W'(0), QUAT_W'(0), QUAT_ONE};
      offset = '{COORD_W'(0), COORD_W'(0), COORD_W'(0)};
      errors = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        REG_QUAT_X:   quat[0] = quat_t'(data[QUAT_W-1:0]);
        REG_QUAT_Y:   quat[1] = quat_t'(data[QUAT_W-1:0]);
        REG_QUAT_Z:   quat[2] = quat_t'(data[QUAT_W-1:0]);
        REG_QUAT_W:   quat[3] = quat_t'(data[QUAT_W-1:0]);
        REG_OFFSET_X: offset[0] = coord_t'(data);
        REG_OFFSET_Y: offset[1] = coord_t'(data);
        REG_OFFSET_Z: offset[2] = coord_t'(data);
        default: ;
      endcase
    endfunction

    function moved_pt_t transform_point(coord_t px, coord_t py, coord_t pz);
      longint    qx, qy, qz, qw;
      longint    m[3][3];
      longint    v[3];
      longint    vh[3];
      longint    vl[3];
      longint    sh, sl, t, r;
      coord_t    res[3];
      logic      clip;
      moved_pt_t pt;
      qx = quat[0];
      qy = quat[1];
      qz = quat[2];
      qw = quat[3];
      m[0][0] = qw * qw + qx * qx - qy * qy - qz * qz;
      m[0][1] = 2 * (qx * qy - qw * qz);
      m[0][2] = 2 * (qx * qz + qw * qy);
      m[1][0] = 2 * (qx * qy + qw * qz);
      m[1][1] = qw * qw - qx * qx + qy * qy - qz * qz;
      m[1][2] = 2 * (qy * qz - qw * qx);
      m[2][0] = 2 * (qx * qz - qw * qy);
      m[2][1] = 2 * (qy * qz + qw * qx);
      m[2][2] = qw * qw - qx * qx - qy * qy + qz * qz;
      v[0] = px;
      v[1] = py;
      v[2] = pz;
      // The exact sum can exceed 64 bits, so it is built from a signed high
      // half and an unsigned low half of each coordinate.
      for (int j = 0; j < 3; j++) begin
        vh[j] = v[j] >>> HALF_W;
        vl[j] = v[j] - vh[j] * 65536;
      end
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        sh = 0;
        sl = longint'(1) <<< ROUND_BIT;
        for (int j = 0; j < 3; j++) begin
          sh += m[i][j] * vh[j];
          sl += m[i][j] * vl[j];
        end
        t = sh + (sl >>> HALF_W);
        r = (t >>> FRAC_SHIFT) + longint'(offset[i]);
        if (r > longint'(32'sh7fff_ffff)) begin
          r = 32'sh7fff_ffff;
          clip = 1'b1;
        end else if (r < -longint'(64'sd2147483648)) begin
          r = -longint'(64'sd2147483648);
          clip = 1'b1;
        end
        res[i] = coord_t'(r);
      end
      pt.x = res[0];
      pt.y = res[1];
      pt.z = res[2];
      pt.clip = clip;
      return pt;
    endfunction

    function void log_point(coord_t px, coord_t py, coord_t pz);
      pending_moves.push_back(transform_point(px, py, pz));
    endfunction

    function void check_field(string name, logic signed [63:0] expected,
                              logic signed [63:0] actual);
      if (expected !== actual) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
        errors++;
      end
    endfunction

    function void match_result(coord_t mx, coord_t my, coord_t mz, logic clip);
      moved_pt_t exp_pt;
      if (pending_moves.size() == 0) begin
        $display("%0t: result with no point outstanding, actual %0d %0d %0d clip %0b",
                 $time, mx, my, mz, clip);
        errors++;
      end else begin
        exp_pt = pending_moves.pop_front();
        check_field("moved_x", exp_pt.x, mx);
        check_field("moved_y", exp_pt.y, my);
        check_field("moved_z", exp_pt.z, mz);
        check_field("clipped", {63'd0, exp_pt.clip}, {{63{clip === 1'bx}}, clip});
      end
    endfunction
  endclass

  transform_scoreboard sb = new();

  quaternion_rigid_transform uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .done      (done),
    .moved_x   (moved_x),
    .moved_y   (moved_y),
    .moved_z   (moved_z),
    .clipped   (clipped),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // Everything is sampled at the edge that completes a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.load_reg(cfg_index, cfg_data);
      if (done === 1'b1) sb.match_result(moved_x, moved_y, moved_z, clipped);
      if (start && !busy) sb.log_point(point_x, point_y, point_z);
    end
  end

  task automatic send_point(coord_t px, coord_t py, coord_t pz);
    int gap;
    start <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if ($urandom_range(0, 99) < gap_rate) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every outstanding point has produced its result.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Quaternion words carry random upper bits, which the block must ignore.
  function automatic logic [COORD_W-1:0] quat_word(int q);
    return {16'($urandom), 16'(q)};
  endfunction

  task automatic apply_config(logic [COORD_W-1:0] vals[NUM_REGS], bit poke_unused);
    int first;
    int idx;
    first = $urandom_range(0, NUM_REGS - 1);
    for (int k = 0; k < NUM_REGS; k++) begin
      idx = (first + k) % NUM_REGS;
      write_reg(CFG_IDX_W'(idx), vals[idx]);
    end
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int qx, int qy, int qz, int qw,
                            coord_t ox, coord_t oy, coord_t oz, bit poke_unused);
    logic [COORD_W-1:0] vals[NUM_REGS];
    vals[REG_QUAT_X] = quat_word(qx);
    vals[REG_QUAT_Y] = quat_word(qy);
    vals[REG_QUAT_Z] = quat_word(qz);
    vals[REG_QUAT_W] = quat_word(qw);
    vals[REG_OFFSET_X] = ox;
    vals[REG_OFFSET_Y] = oy;
    vals[REG_OFFSET_Z] = oz;
    apply_config(vals, poke_unused);
  endtask

  function automatic coord_t rand_offset();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return coord_t'($urandom_range(0, 32'd2097152) - 32'd1048576);
    if (roll < 80) return coord_t'($urandom);
    return coord_edges[$urandom_range(0, 3)];
  endfunction

  function automatic coord_t rand_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return coord_t'($urandom_range(0, 32'd2097152) - 32'd1048576);
    if (roll < 85) return coord_t'($urandom);
    return coord_edges[$urandom_range(0, 7)];
  endfunction

  task automatic random_config();
    int q[4];
    int row;
    int mode;
    mode = $urandom_range(0, 3);
    row = $urandom_range(0, 7);
    for (int c = 0; c < 4; c++) begin
      case (mode)
        0: q[c] = unit_q[row][c];
        1: q[c] = int'($urandom_range(0, 32768)) - 16384;
        2: q[c] = int'(16'($urandom));
        default: q[c] = quat_edges[$urandom_range(0, 6)];
      endcase
    end
    // q and -q describe the same rotation.
    if (mode == 0 && $urandom_range(0, 1)) begin
      for (int c = 0; c < 4; c++) q[c] = -q[c];
    end
    set_config(q[0], q[1], q[2], q[3], rand_offset(), rand_offset(), rand_offset(),
               $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    point_x <= '0;
    point_y <= '0;
    point_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    gap_rate = 25;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values give the identity transform.
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, -32'sd1);
    send_point(32'sd1, 32'sh0000_8000, 32'sh1234_5678);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);

    // Scale by one quarter: ties round toward positive infinity.
    drain();
    set_config(0, 0, 0, 8192, 32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_point(32'sd2, -32'sd2, 32'sd6);
    send_point(-32'sd6, 32'sd1, -32'sd1);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sd0);

    // Quarter turn about z with offsets that push results past both bounds.
    drain();
    set_config(0, 0, 11585, 11585, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd65536, 1'b0);
    send_point(32'sd655360, 32'sd655360, 32'sd655360);
    send_point(-32'sd655360, -32'sd655360, -32'sd655360);
    send_point(32'sd0, 32'sd0, 32'sh7fff_ffff);

    // Quaternion components outside the nominal range, plus a write to an
    // index with no register behind it.
    drain();
    set_config(-32768, -32768, -32768, -32768, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sd1, 32'sh0001_0000);
    send_point(-32'sd1, -32'sd1, -32'sd1);

    // Half turn about x.
    drain();
    set_config(16384, 0, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sd65536, 32'sd65536, 32'sd65536);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    send_point(32'sh7fff_ffff, -32'sd65536, 32'sh0000_8000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      random_config();
      gap_rate = (phase % 2) ? 0 : 35;
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        if (phase == 3 && n == POINTS_PER_PHASE / 2) drain();
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/qrt_pkg.sv
hw/rtl/qrt_coef.sv
hw/rtl/qrt_row.sv
hw/rtl/quaternion_rigid_transform.sv
tb/sv/testbench.sv
